// ===== rtl/efc_pkg.sv =====
// Package of the elevator controller: default sizes, item codes and the
// status struct of the request queue. Depends on nothing.
`default_nettype none
package efc_pkg;
   localparam int DEF_FLOORS       = 8;
   localparam int DEF_FLOOR_PIXELS = 64;
   localparam int DEF_SLOTS        = 16;
   localparam int MOVE_STEP        = 2;
   localparam int DWELL_RESET      = 30;

   localparam logic [1:0] FUNC_TICK  = 2'd0;
   localparam logic [1:0] FUNC_ADD   = 2'd1;
   localparam logic [1:0] FUNC_PAUSE = 2'd2;

   typedef struct packed {
      logic empty;
      logic full;
   } q_status_type;
endpackage
`default_nettype wire

// ===== rtl/efc_ram.sv =====
// Simple dual-port synchronous RAM, one write and one registered read port.
// Used for the passenger tables of the elevator controller; no dependencies.
`default_nettype none
module efc_ram #(
   parameter int WIDTH = 6,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AW-1:0]    waddr,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic [AW-1:0]    raddr,
   output logic      [WIDTH-1:0] rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule
`default_nettype wire

// ===== rtl/efc_queue.sv =====
// Request queue of the elevator controller: a circular buffer in memory with a
// per-floor mask that rejects duplicates. Depends on efc_pkg.
`default_nettype none
module efc_queue #(
   parameter int FLOORS = 8,
   parameter int FW     = $clog2(FLOORS)
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push_en,
   input  wire logic [FW-1:0]         push_floor,
   input  wire logic                  pop_en,
   output logic      [FW-1:0]         head_floor,
   output efc_pkg::q_status_type      status
);
   import efc_pkg::*;

   localparam int QW = $clog2(FLOORS);
   localparam int CW = $clog2(FLOORS + 1);

   logic [FW-1:0]     mem [FLOORS];
   logic [FW-1:0]     rd_ff;
   logic [QW-1:0]     head_ff, tail_ff;
   logic [CW-1:0]     count_ff;
   logic [FLOORS-1:0] queued_ff;
   logic              full;

   assign full = (count_ff == CW'(FLOORS));

   function automatic logic [QW-1:0] bump(input logic [QW-1:0] p);
      bump = (p == QW'(FLOORS - 1)) ? '0 : p + 1'b1;
   endfunction

   // Storage and head read; the head entry is read through a register.
   always_ff @(posedge clock) begin
      if (push_en && !queued_ff[push_floor] && !full) begin
         mem[tail_ff] <= push_floor;
      end
      rd_ff <= mem[head_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff   <= '0;
         tail_ff   <= '0;
         count_ff  <= '0;
         queued_ff <= '0;
      end else if (push_en) begin
         if (!queued_ff[push_floor] && !full) begin
            tail_ff               <= bump(tail_ff);
            count_ff              <= count_ff + 1'b1;
            queued_ff[push_floor] <= 1'b1;
         end
      end else if (pop_en && count_ff != '0) begin
         head_ff          <= bump(head_ff);
         count_ff         <= count_ff - 1'b1;
         queued_ff[rd_ff] <= 1'b0;
      end
   end

   assign head_floor   = rd_ff;
   assign status.empty = (count_ff == '0);
   assign status.full  = full;
endmodule
`default_nettype wire

// ===== rtl/fifo_elevator_controller.sv =====
// Top level of the single-cab elevator controller.
// Depends on efc_pkg, efc_ram and efc_queue.
`default_nettype none
// An item is taken when start is high and busy is low; its result appears for
// exactly one cycle with rsp_valid high, and the receiver cannot hold it off.
// Pause, add and idle ticks go from the accepting cycle straight to the strobe.
// A tick that moves the cab first picks the target and takes a travel step. A
// tick that arrives then walks the waiting and riding tables, pops the queue and
// clears the floor's lamps: the tables live in single-read memories and arrival
// walks each table entry by entry (address, then compare and write back
// compacted). The request queue is a circular buffer with a per-floor mask, so
// duplicate checks cost nothing. The user must write dwell_ticks through csr_we
// and csr_wdata only while the block is idle; the block does not enforce it.
module fifo_elevator_controller #(
   parameter int FLOORS          = efc_pkg::DEF_FLOORS,
   parameter int FLOOR_PIXELS    = efc_pkg::DEF_FLOOR_PIXELS,
   parameter int PASSENGER_SLOTS = efc_pkg::DEF_SLOTS,
   parameter int FW = $clog2(FLOORS),
   parameter int PW = $clog2((FLOORS - 1) * FLOOR_PIXELS + 1),
   parameter int CW = $clog2(PASSENGER_SLOTS + 1)
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire logic [1:0]        req_func,
   input  wire logic [FW-1:0]     req_start_floor,
   input  wire logic [FW-1:0]     req_dest_floor,
   input  wire logic              req_going_up,
   input  wire logic              csr_we,
   input  wire logic [7:0]        csr_wdata,
   output logic                   rsp_valid,
   output logic      [PW-1:0]     rsp_cabin_position,
   output logic      [FW-1:0]     rsp_current_floor,
   output logic                   rsp_moving,
   output logic                   rsp_moving_up,
   output logic                   rsp_paused,
   output logic      [CW-1:0]     rsp_riding_count,
   output logic      [CW-1:0]     rsp_waiting_count,
   output logic      [15:0]       rsp_delivered_count,
   output logic                   rsp_arrived,
   output logic                   rsp_add_rejected,
   output logic      [FLOORS-1:0] rsp_up_lamps,
   output logic      [FLOORS-1:0] rsp_down_lamps
);
   import efc_pkg::*;

   localparam int AW = (PASSENGER_SLOTS > 1) ? $clog2(PASSENGER_SLOTS) : 1;
   localparam logic [PW-1:0] POS_RESET = PW'((FLOORS - 1) * FLOOR_PIXELS);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_TGT  = 4'd1;
   localparam logic [3:0] S_MOVE = 4'd2;
   localparam logic [3:0] S_WRD  = 4'd3;
   localparam logic [3:0] S_WPR  = 4'd4;
   localparam logic [3:0] S_RRD  = 4'd5;
   localparam logic [3:0] S_RPR  = 4'd6;
   localparam logic [3:0] S_POP  = 4'd7;
   localparam logic [3:0] S_LEFT = 4'd8;
   localparam logic [3:0] S_EMIT = 4'd9;

   logic [3:0]        state_ff;
   logic [PW-1:0]     pos_ff, target_ff;
   logic [FW-1:0]     floor_ff, head_ff;
   logic              mv_ff, up_ff, pause_ff, left_ff;
   logic              arrived_ff, rejected_ff;
   logic [7:0]        dwell_ff, dwell_ticks_ff;
   logic [CW-1:0]     wait_n_ff, ride_n_ff, idx_ff, k_ff;
   logic [FLOORS-1:0] up_lamp_ff, down_lamp_ff;
   logic [15:0]       delivered_ff;

   // Queue interface.
   logic          q_push, q_pop;
   logic [FW-1:0] q_push_floor, q_head;
   q_status_type  q_status;

   efc_queue #(.FLOORS(FLOORS), .FW(FW)) u_queue (
      .clock(clock), .reset(reset), .push_en(q_push), .push_floor(q_push_floor),
      .pop_en(q_pop), .head_floor(q_head), .status(q_status)
   );

   // Waiting table: entries hold {start floor, destination floor}.
   logic              w_we;
   logic [AW-1:0]     w_waddr;
   logic [2*FW-1:0]   w_wdata, w_rdata;
   logic              r_we;
   logic [AW-1:0]     r_waddr;
   logic [FW-1:0]     r_wdata, r_rdata;

   efc_ram #(.WIDTH(2*FW), .DEPTH(PASSENGER_SLOTS), .AW(AW)) u_wait (
      .clock(clock), .we(w_we), .waddr(w_waddr), .wdata(w_wdata),
      .raddr(idx_ff[AW-1:0]), .rdata(w_rdata)
   );

   efc_ram #(.WIDTH(FW), .DEPTH(PASSENGER_SLOTS), .AW(AW)) u_ride (
      .clock(clock), .we(r_we), .waddr(r_waddr), .wdata(r_wdata),
      .raddr(idx_ff[AW-1:0]), .rdata(r_rdata)
   );

   logic accept, add_ok, boards;
   logic [FW-1:0] w_start, w_dest;

   assign accept  = start && !busy;
   assign add_ok  = (wait_n_ff < CW'(PASSENGER_SLOTS))
                    && (32'(req_start_floor) < FLOORS) && (32'(req_dest_floor) < FLOORS);
   assign w_start = w_rdata[2*FW-1:FW];
   assign w_dest  = w_rdata[FW-1:0];
   assign boards  = (w_start == head_ff) && (ride_n_ff < CW'(PASSENGER_SLOTS));

   // Memory write and queue push and pop selection.
   always_comb begin
      w_we         = 1'b0;
      w_waddr      = wait_n_ff[AW-1:0];
      w_wdata      = {req_start_floor, req_dest_floor};
      r_we         = 1'b0;
      r_waddr      = ride_n_ff[AW-1:0];
      r_wdata      = w_dest;
      q_push       = 1'b0;
      q_push_floor = req_start_floor;
      q_pop        = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (accept && req_func == FUNC_ADD && add_ok) begin
               w_we   = 1'b1;
               q_push = 1'b1;
            end
         end
         S_WPR: begin
            if (boards) begin
               r_we         = 1'b1;
               q_push       = 1'b1;
               q_push_floor = w_dest;
            end else begin
               w_we    = 1'b1;
               w_waddr = k_ff[AW-1:0];
               w_wdata = w_rdata;
            end
         end
         S_RPR: begin
            if (r_rdata != head_ff) begin
               r_we    = 1'b1;
               r_waddr = k_ff[AW-1:0];
               r_wdata = r_rdata;
            end
         end
         S_POP:  q_pop = 1'b1;
         S_LEFT: begin
            q_push       = left_ff;
            q_push_floor = head_ff;
         end
         default: ;
      endcase
   end

   // One step of travel toward the target, with the arrival test.
   logic          up_in;
   logic [PW:0]   pos_x, tgt_x, pos_step, diff;
   logic [PW-1:0] pos_in;
   logic          arrive_now;

   always_comb begin
      pos_x = {1'b0, pos_ff};
      tgt_x = {1'b0, target_ff};
      up_in = mv_ff ? up_ff : (pos_ff > target_ff);
      if (up_in) begin
         pos_step = (pos_x >= tgt_x + (PW+1)'(MOVE_STEP)) ? pos_x - (PW+1)'(MOVE_STEP)
                                                          : tgt_x;
      end else begin
         pos_step = (pos_x + (PW+1)'(MOVE_STEP) <= tgt_x) ? pos_x + (PW+1)'(MOVE_STEP)
                                                          : tgt_x;
      end
      diff       = (pos_step > tgt_x) ? pos_step - tgt_x : tgt_x - pos_step;
      arrive_now = diff < (PW+1)'(MOVE_STEP);
      pos_in     = arrive_now ? target_ff : pos_step[PW-1:0];
   end

   logic [FW-1:0] fdiff;
   assign fdiff = FW'(FLOORS - 1) - q_head;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         pos_ff         <= POS_RESET;
         floor_ff       <= '0;
         mv_ff          <= 1'b0;
         up_ff          <= 1'b0;
         pause_ff       <= 1'b0;
         dwell_ff       <= '0;
         dwell_ticks_ff <= 8'(DWELL_RESET);
         wait_n_ff      <= '0;
         ride_n_ff      <= '0;
         up_lamp_ff     <= '0;
         down_lamp_ff   <= '0;
         delivered_ff   <= '0;
         arrived_ff     <= 1'b0;
         rejected_ff    <= 1'b0;
         left_ff        <= 1'b0;
         idx_ff         <= '0;
         k_ff           <= '0;
      end else begin
         if (csr_we) begin
            dwell_ticks_ff <= csr_wdata;
         end
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  arrived_ff  <= 1'b0;
                  rejected_ff <= 1'b0;
                  state_ff    <= S_EMIT;
                  case (req_func)
                     FUNC_TICK: begin
                        if (!pause_ff && !q_status.empty) begin
                           if (dwell_ff != '0) begin
                              dwell_ff <= dwell_ff - 1'b1;
                           end else begin
                              state_ff <= S_TGT;
                           end
                        end
                     end
                     FUNC_ADD: begin
                        if (add_ok) begin
                           wait_n_ff <= wait_n_ff + 1'b1;
                           if (req_going_up) begin
                              up_lamp_ff[req_start_floor] <= 1'b1;
                           end else begin
                              down_lamp_ff[req_start_floor] <= 1'b1;
                           end
                        end else begin
                           rejected_ff <= 1'b1;
                        end
                     end
                     FUNC_PAUSE: pause_ff <= !pause_ff;
                     default: ;
                  endcase
               end
            end
            S_TGT: begin
               head_ff   <= q_head;
               target_ff <= PW'(PW'(fdiff) * PW'(FLOOR_PIXELS));
               state_ff  <= S_MOVE;
            end
            S_MOVE: begin
               pos_ff <= pos_in;
               up_ff  <= up_in;
               if (arrive_now) begin
                  mv_ff    <= 1'b0;
                  floor_ff <= head_ff;
                  idx_ff   <= '0;
                  k_ff     <= '0;
                  left_ff  <= 1'b0;
                  state_ff <= S_WRD;
               end else begin
                  mv_ff    <= 1'b1;
                  state_ff <= S_EMIT;
               end
            end
            S_WRD: begin
               if (idx_ff == wait_n_ff) begin
                  wait_n_ff <= k_ff;
                  idx_ff    <= '0;
                  k_ff      <= '0;
                  state_ff  <= S_RRD;
               end else begin
                  state_ff <= S_WPR;
               end
            end
            S_WPR: begin
               if (boards) begin
                  ride_n_ff <= ride_n_ff + 1'b1;
               end else begin
                  k_ff <= k_ff + 1'b1;
                  if (w_start == head_ff) begin
                     left_ff <= 1'b1;
                  end
               end
               idx_ff   <= idx_ff + 1'b1;
               state_ff <= S_WRD;
            end
            S_RRD: begin
               if (idx_ff == ride_n_ff) begin
                  ride_n_ff <= k_ff;
                  state_ff  <= S_POP;
               end else begin
                  state_ff <= S_RPR;
               end
            end
            S_RPR: begin
               if (r_rdata == head_ff) begin
                  delivered_ff <= delivered_ff + 1'b1;
               end else begin
                  k_ff <= k_ff + 1'b1;
               end
               idx_ff   <= idx_ff + 1'b1;
               state_ff <= S_RRD;
            end
            S_POP:  state_ff <= S_LEFT;
            S_LEFT: begin
               up_lamp_ff[head_ff]   <= 1'b0;
               down_lamp_ff[head_ff] <= 1'b0;
               dwell_ff              <= dwell_ticks_ff;
               arrived_ff            <= 1'b1;
               state_ff              <= S_EMIT;
            end
            S_EMIT:  state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign busy                = (state_ff != S_IDLE);
   assign rsp_valid           = (state_ff == S_EMIT);
   assign rsp_cabin_position  = pos_ff;
   assign rsp_current_floor   = floor_ff;
   assign rsp_moving          = mv_ff;
   assign rsp_moving_up       = up_ff;
   assign rsp_paused          = pause_ff;
   assign rsp_riding_count    = ride_n_ff;
   assign rsp_waiting_count   = wait_n_ff;
   assign rsp_delivered_count = delivered_ff;
   assign rsp_arrived         = arrived_ff;
   assign rsp_add_rejected    = rejected_ff;
   assign rsp_up_lamps        = up_lamp_ff;
   assign rsp_down_lamps      = down_lamp_ff;
endmodule
`default_nettype wire

// ===== rtl/efc_checker.sv =====
// Port-level checker of the elevator controller and its bind statement.
// Depends on fifo_elevator_controller being elaborated.
`default_nettype none
module efc_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   input wire logic busy,
   input wire logic rsp_valid,
   input wire logic rsp_arrived,
   input wire logic rsp_moving
);
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result strobe longer than one cycle");

   a_busy_on_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("item accepted but block not busy");

   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy) else $error("result shown while idle");

   a_arrival_stops: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_arrived) |-> !rsp_moving) else $error("arrived while moving");
endmodule

bind fifo_elevator_controller efc_checker u_efc_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_valid(rsp_valid), .rsp_arrived(rsp_arrived), .rsp_moving(rsp_moving)
);
`default_nettype wire
